// ===== rtl/brf_pkg.sv =====
// Shared types, codes and defaults of the byte ring FIFO with burst reads.
`timescale 1ns / 1ps

package brf_pkg;

	localparam int DEPTH_DEF     = 1024;
	localparam int MAX_BURST_DEF = 64;

	localparam int CAP_W   = 11;
	localparam int CMD_W   = 2;
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 7;
	localparam int KIND_W  = 2;
	localparam int OCC_W   = 11;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REFUSED = 2'd2;
	localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]   cmd;
		logic [BYTE_W-1:0]  data_in;
		logic [COUNT_W-1:0] read_count;
	} in_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] data_out;
		logic              accepted;
		logic              last;
		logic [OCC_W-1:0]  occupancy;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_READ,
		OP_REFUSE,
		OP_CLEAR
	} op_e;

	typedef struct packed {
		op_e                op;
		logic [BYTE_W-1:0]  data;
		logic [COUNT_W-1:0] count;
	} op_t;

	typedef struct packed {
		logic push;
		op_t  entry;
	} push_req_t;

endpackage

// ===== rtl/brf_front.sv =====
// Front end: accepts input requests and classifies them into queue operations.
`timescale 1ns / 1ps

module brf_front #(
	parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
	input  logic                in_valid,
	output logic                in_stall,
	input  brf_pkg::in_item_t   in_item,
	input  logic                q_full,
	output brf_pkg::push_req_t  push_req
);

	logic accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	always_comb begin
		push_req.entry.data  = in_item.data_in;
		push_req.entry.count = in_item.read_count;
		push_req.entry.op    = brf_pkg::OP_WRITE;
		push_req.push        = accept;
		case (in_item.cmd)
			brf_pkg::CMD_WRITE: begin
				push_req.entry.op = brf_pkg::OP_WRITE;
			end
			brf_pkg::CMD_READ: begin
				// out-of-range counts are refused here; the stored-byte check is in the back end
				if (int'(in_item.read_count) inside {[1:MAX_BURST]}) begin
					push_req.entry.op = brf_pkg::OP_READ;
				end else begin
					push_req.entry.op = brf_pkg::OP_REFUSE;
				end
			end
			brf_pkg::CMD_CLEAR: begin
				push_req.entry.op = brf_pkg::OP_CLEAR;
			end
			default: begin
				// unused command: drop, no result
				push_req.push = 1'b0;
			end
		endcase
	end

endmodule

// ===== rtl/brf_queue.sv =====
// Short operation queue between the front end and the back end.
`timescale 1ns / 1ps

module brf_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  brf_pkg::push_req_t push_req,
	output logic               full,
	input  logic               pop,
	output logic               empty,
	output brf_pkg::op_t       head
);

	brf_pkg::op_t                entries_q [brf_pkg::QUEUE_DEPTH];
	logic [brf_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [brf_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [brf_pkg::QCNT_W-1:0]  cnt_q;
	logic                        do_push;
	logic                        do_pop;

	assign full    = (cnt_q == brf_pkg::QCNT_W'(brf_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign head    = entries_q[rd_ptr_q];
	assign do_push = push_req.push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_req.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/brf_back.sv =====
// Back end: ring store, positions, fill count and the result pipeline.
`timescale 1ns / 1ps

module brf_back #(
	parameter int DEPTH = brf_pkg::DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [brf_pkg::CAP_W-1:0]     cfg_wr_data,
	input  logic                          q_empty,
	input  brf_pkg::op_t                  q_head,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output brf_pkg::out_item_t            out_item
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = (CW > brf_pkg::CAP_W) ? CW : brf_pkg::CAP_W;

	logic [brf_pkg::BYTE_W-1:0] store [DEPTH];
	logic [brf_pkg::BYTE_W-1:0] rd_data_q;

	logic [CW-1:0]  ring_q;
	logic [PW-1:0]  last_idx_q;
	logic [PW-1:0]  wpos_q;
	logic [PW-1:0]  rpos_q;
	logic [CW-1:0]  fill_q;
	logic [brf_pkg::COUNT_W-1:0] k_q;

	logic [SW-1:0]  cap_ext;
	logic [CW-1:0]  ring_new;

	logic                        valid_s1;
	logic [brf_pkg::KIND_W-1:0]  kind_s1;
	logic                        acc_s1;
	logic                        last_s1;
	logic [brf_pkg::OCC_W-1:0]   occ_s1;

	logic                        s2_free;
	logic                        issue_ok;
	logic                        issue;
	logic                        room;
	logic                        refuse;
	logic                        burst_last;
	logic                        mem_we;
	logic                        mem_re;
	logic [CW-1:0]               fill_nx;
	logic [brf_pkg::KIND_W-1:0]  kind_nx;
	logic                        acc_nx;
	logic                        last_nx;

	// clamp the capacity register to 1..DEPTH
	always_comb begin
		cap_ext = SW'(cfg_wr_data);
		if (cap_ext == '0) begin
			ring_new = CW'(1);
		end else if (cap_ext > SW'(DEPTH)) begin
			ring_new = CW'(DEPTH);
		end else begin
			ring_new = CW'(cap_ext);
		end
	end

	assign s2_free  = !out_valid || !out_stall;
	assign issue_ok = !valid_s1 || s2_free;
	assign issue    = issue_ok && !q_empty;

	assign room       = (fill_q < ring_q);
	assign refuse     = (k_q == '0) && (SW'(q_head.count) > SW'(fill_q));
	assign burst_last = ((k_q + 1'b1) == q_head.count);

	always_comb begin
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		q_pop   = 1'b0;
		fill_nx = fill_q;
		kind_nx = brf_pkg::KIND_WRITE;
		acc_nx  = 1'b0;
		last_nx = 1'b1;
		case (q_head.op)
			brf_pkg::OP_WRITE: begin
				q_pop  = issue;
				mem_we = issue && room;
				acc_nx = room;
				if (room) begin
					fill_nx = fill_q + 1'b1;
				end
			end
			brf_pkg::OP_READ: begin
				if (refuse) begin
					q_pop   = issue;
					kind_nx = brf_pkg::KIND_REFUSED;
				end else begin
					q_pop   = issue && burst_last;
					mem_re  = issue;
					kind_nx = brf_pkg::KIND_BYTE;
					last_nx = burst_last;
					fill_nx = fill_q - 1'b1;
				end
			end
			brf_pkg::OP_REFUSE: begin
				q_pop   = issue;
				kind_nx = brf_pkg::KIND_REFUSED;
			end
			brf_pkg::OP_CLEAR: begin
				q_pop   = issue;
				kind_nx = brf_pkg::KIND_CLEAR;
				fill_nx = '0;
			end
			default: begin
				q_pop = issue;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store[wpos_q] <= q_head.data;
		end
		if (mem_re) begin
			rd_data_q <= store[rpos_q];
		end
	end

	// ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_q     <= CW'(DEPTH);
			last_idx_q <= PW'(DEPTH - 1);
			wpos_q     <= '0;
			rpos_q     <= '0;
			fill_q     <= '0;
			k_q        <= '0;
		end else if (cfg_wr_en) begin
			ring_q     <= ring_new;
			last_idx_q <= PW'(ring_new - 1'b1);
			wpos_q     <= '0;
			rpos_q     <= '0;
			fill_q     <= '0;
			k_q        <= '0;
		end else if (issue) begin
			fill_q <= fill_nx;
			if (mem_we) begin
				wpos_q <= (wpos_q == last_idx_q) ? '0 : wpos_q + 1'b1;
			end
			if (mem_re) begin
				rpos_q <= (rpos_q == last_idx_q) ? '0 : rpos_q + 1'b1;
				k_q    <= burst_last ? '0 : k_q + 1'b1;
			end
			if (q_head.op == brf_pkg::OP_CLEAR) begin
				wpos_q <= '0;
				rpos_q <= '0;
			end
		end
	end

	// result pipeline: issue stage, then output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (issue_ok) begin
				valid_s1 <= issue;
			end
			if (s2_free) begin
				out_valid <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			kind_s1 <= kind_nx;
			acc_s1  <= acc_nx;
			last_s1 <= last_nx;
			occ_s1  <= brf_pkg::OCC_W'(SW'(fill_nx));
		end
		if (s2_free && valid_s1) begin
			out_item.kind      <= kind_s1;
			out_item.data_out  <= (kind_s1 == brf_pkg::KIND_BYTE) ? rd_data_q : '0;
			out_item.accepted  <= acc_s1;
			out_item.last      <= last_s1;
			out_item.occupancy <= occ_s1;
		end
	end

endmodule

// ===== rtl/byte_ring_fifo_burst_read_top.sv =====
// Top level of the byte ring FIFO with all-or-nothing burst reads.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake             Payload
// cfg       in         cfg_wr_en             cfg_wr_data (capacity, 11 bits)
// in        in         in_valid / in_stall   in_item  (cmd, data_in, read_count)
// out       out        out_valid / out_stall out_item (kind, data_out, accepted,
//                                                      last, occupancy)
//
// Cycles: one result per cycle unless stalled; write, clear and refused reads
// give one result each, a burst of N bytes gives N results, paced by the single
// store read port. A request passes the queue, issue stage and output register.
// Reset: asynchronous; positions and fill count clear at once, store contents
// stay undefined (no clearing pass, a clear only resets positions and count).
// Stalls: out_stall backs up the result pipeline, then the 4-entry queue, then
// in_stall; an unused command is dropped by the front end with no result.
//
// Structure: brf_front classifies requests, brf_queue decouples the sides,
// brf_back owns the ring store, positions, fill count and output register.

module byte_ring_fifo_burst_read_top #(
	parameter int DEPTH     = brf_pkg::DEPTH_DEF,
	parameter int MAX_BURST = brf_pkg::MAX_BURST_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [brf_pkg::CAP_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  brf_pkg::in_item_t         in_item,
	output logic                      out_valid,
	input  logic                      out_stall,
	output brf_pkg::out_item_t        out_item
);

	brf_pkg::push_req_t push_req;
	brf_pkg::op_t       q_head;
	logic               q_full;
	logic               q_empty;
	logic               q_pop;

	// classify and push requests
	brf_front #(
		.MAX_BURST (MAX_BURST)
	) u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_full   (q_full),
		.push_req (push_req)
	);

	// hold pending operations so each side can stall on its own
	brf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_req (push_req),
		.full     (q_full),
		.pop      (q_pop),
		.empty    (q_empty),
		.head     (q_head)
	);

	// execute operations against the ring and deliver results
	brf_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.q_empty     (q_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

endmodule
